/* hw/rtl/trace_packet_parser_assert.svh */
// assertion macros for the trace packet parser
`ifndef TRACE_PACKET_PARSER_ASSERT_SVH
`define TRACE_PACKET_PARSER_ASSERT_SVH

// checked on every clock edge outside reset
`define TPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define TPP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/tpp_pkg.sv */
// types, byte codes and helpers for the trace packet parser
package tpp_pkg;

  parameter int unsigned SignBitsDefault = 48;

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_EXT  = 3'd1,
    PH_SYNC = 3'd2,
    PH_SKIP = 3'd3,
    PH_ADDR = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_TNT  = 3'd0,
    EV_TIP  = 3'd1,
    EV_PGE  = 3'd2,
    EV_PGD  = 3'd3,
    EV_FUP  = 3'd4,
    EV_HEND = 3'd5,
    EV_STOP = 3'd6,
    EV_ERR  = 3'd7
  } event_e;

  // whole-byte codes
  localparam logic [7:0] BytePad    = 8'h00;
  localparam logic [7:0] ByteExt    = 8'h02;
  localparam logic [7:0] ByteMode   = 8'h99;
  localparam logic [7:0] ByteStop   = 8'h55;
  localparam logic [7:0] ByteSyncHi = 8'h82;
  localparam logic [7:0] ByteRate   = 8'h03;
  localparam logic [7:0] ByteHend   = 8'h23;
  localparam logic [7:0] ByteVmcs   = 8'hC8;

  // low five bits of address packet headers
  localparam logic [4:0] HdrFup = 5'b11101;
  localparam logic [4:0] HdrPge = 5'b10001;
  localparam logic [4:0] HdrPgd = 5'b00001;
  localparam logic [4:0] HdrTip = 5'b01101;

  // compression codes
  localparam logic [2:0] CmpNone  = 3'd0;
  localparam logic [2:0] Cmp16    = 3'd1;
  localparam logic [2:0] Cmp32    = 3'd2;
  localparam logic [2:0] CmpSext  = 3'd3;
  localparam logic [2:0] Cmp48    = 3'd4;
  localparam logic [2:0] CmpRsvdA = 3'd5;
  localparam logic [2:0] CmpFull  = 3'd6;
  localparam logic [2:0] CmpRsvdB = 3'd7;

  localparam logic [3:0] SyncLen = 4'd14;
  localparam logic [3:0] RateLen = 4'd2;
  localparam logic [3:0] VmcsLen = 4'd5;
  localparam logic [3:0] ModeLen = 4'd1;

  localparam logic [63:0] Low48Mask = 64'hFFFF_FFFF_FFFF;

  function automatic logic [3:0] payload_len(input logic [2:0] code);
    logic [3:0] len;
    unique case (code)
      Cmp16:   len = 4'd2;
      Cmp32:   len = 4'd4;
      CmpSext: len = 4'd6;
      Cmp48:   len = 4'd6;
      CmpFull: len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/trace_packet_parser.sv */
// Trace packet parser: one trace byte per word in, at most one event word out.
// Input channel: trace_byte_i with trace_byte_valid_i / trace_byte_ready_o.
// Output channel: event_res_o, branch_bits_o, branch_count_o, target_address_o
// with result_valid_o / result_ready_i.
// Each accepted byte is decoded in the cycle it is taken, against the parse
// state, and any event it produces lands in the output register at that edge,
// so an event is visible in the cycle after its last byte is accepted.
// Throughput is one byte per cycle while the output is not held by a stalled receiver;
// the only loop is the parse state update. When the receiver stalls, the output register
// holds its event and no byte is taken: trace_byte_ready_o is low while the output is
// full and result_ready_i is low, so every byte waits for the held word to leave,
// and input resumes in the cycle the receiver raises result_ready_i.
// Reset puts the parser at the top level outside any sync header, with the
// last address at zero and the output empty.
// Errors are reported as an event; parsing restarts at the top level with
// the next byte and the last address is kept.
module trace_packet_parser #(
  parameter int unsigned SIGN_BITS = tpp_pkg::SignBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        trace_byte_valid_i,
  output logic        trace_byte_ready_o,
  input  logic [7:0]  trace_byte_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [2:0]  event_res_o,
  output logic [5:0]  branch_bits_o,
  output logic [2:0]  branch_count_o,
  output logic [63:0] target_address_o
);

  `include "trace_packet_parser_assert.svh"

  localparam logic [63:0] HiMask = ~64'h0 << SIGN_BITS;

  tpp_pkg::phase_e phase_q, phase_d;
  logic [3:0]      bytes_left_q, bytes_left_d;
  tpp_pkg::event_e packet_type_q, packet_type_d;
  logic [2:0]      code_q, code_d;
  logic [63:0]     accum_q, accum_d;
  logic [63:0]     last_addr_q, last_addr_d;
  logic            in_sync_q, in_sync_d;

  logic            out_valid_q, out_valid_d;
  tpp_pkg::event_e out_event_q;
  logic [5:0]      out_bits_q;
  logic [2:0]      out_count_q;
  logic [63:0]     out_addr_q;

  logic            res_valid;
  tpp_pkg::event_e res_event;
  logic [5:0]      res_bits;
  logic [2:0]      res_count;
  logic [63:0]     res_addr;

  logic            accept;
  logic [4:0]      low5;
  logic [2:0]      hdr_code;
  logic            hdr_bad;
  logic [3:0]      hdr_len;
  logic            hdr_addr;
  tpp_pkg::event_e hdr_event;
  logic [2:0]      tnt_count;
  logic [5:0]      tnt_bits;
  logic [7:0]      sync_want;
  logic [63:0]     accum_new;
  logic [63:0]     payload;
  logic [63:0]     payload48;
  logic [63:0]     addr_sext;
  logic [63:0]     addr_rebuilt;
  logic            last_byte;

  assign trace_byte_ready_o = !out_valid_q || result_ready_i;
  assign accept = trace_byte_valid_i && trace_byte_ready_o;

  assign low5     = trace_byte_i[4:0];
  assign hdr_code = trace_byte_i[7:5];
  assign hdr_bad  = (hdr_code == tpp_pkg::CmpRsvdA) || (hdr_code == tpp_pkg::CmpRsvdB);
  assign hdr_len  = tpp_pkg::payload_len(hdr_code);

  // fup is legal inside a sync header, the other address packets are not
  always_comb begin
    hdr_addr  = 1'b1;
    hdr_event = tpp_pkg::EV_FUP;
    if (low5 == tpp_pkg::HdrFup) begin
      hdr_event = tpp_pkg::EV_FUP;
    end else if (!in_sync_q && low5 == tpp_pkg::HdrPge) begin
      hdr_event = tpp_pkg::EV_PGE;
    end else if (!in_sync_q && low5 == tpp_pkg::HdrPgd) begin
      hdr_event = tpp_pkg::EV_PGD;
    end else if (!in_sync_q && low5 == tpp_pkg::HdrTip) begin
      hdr_event = tpp_pkg::EV_TIP;
    end else begin
      hdr_addr = 1'b0;
    end
  end

  // short tnt: highest set bit above bit 1 marks the end of the branch bits
  always_comb begin
    tnt_count = 3'd0;
    for (int i = 2; i < 8; i++) begin
      if (trace_byte_i[i]) begin
        tnt_count = 3'(i - 1);
      end
    end
  end
  assign tnt_bits = trace_byte_i[6:1] & 6'((7'd1 << tnt_count) - 7'd1);

  assign sync_want = bytes_left_q[0] ? tpp_pkg::ByteSyncHi : tpp_pkg::ByteExt;

  // payload is little endian: each byte enters at the top
  assign accum_new = {trace_byte_i, accum_q[63:8]};
  assign last_byte = (bytes_left_q <= 4'd1);

  always_comb begin
    case (tpp_pkg::payload_len(code_q))
      4'd2:    payload = {48'h0, accum_new[63:48]};
      4'd4:    payload = {32'h0, accum_new[63:32]};
      4'd6:    payload = {16'h0, accum_new[63:16]};
      default: payload = accum_new;
    endcase
  end

  assign payload48 = payload & tpp_pkg::Low48Mask;
  assign addr_sext = payload48[SIGN_BITS-1] ? (payload48 | HiMask) : (payload48 & ~HiMask);

  always_comb begin
    case (code_q)
      tpp_pkg::Cmp16:   addr_rebuilt = {last_addr_q[63:16], payload[15:0]};
      tpp_pkg::Cmp32:   addr_rebuilt = {last_addr_q[63:32], payload[31:0]};
      tpp_pkg::CmpSext: addr_rebuilt = addr_sext;
      tpp_pkg::Cmp48:   addr_rebuilt = {last_addr_q[63:48], payload[47:0]};
      tpp_pkg::CmpFull: addr_rebuilt = payload;
      default:          addr_rebuilt = last_addr_q;
    endcase
  end

  // next parse state
  always_comb begin
    phase_d       = phase_q;
    bytes_left_d  = bytes_left_q;
    packet_type_d = packet_type_q;
    code_d        = code_q;
    accum_d       = accum_q;
    last_addr_d   = last_addr_q;
    in_sync_d     = in_sync_q;
    if (accept) begin
      unique case (phase_q)
        tpp_pkg::PH_EXT: begin
          phase_d = tpp_pkg::PH_TOP;
          if (trace_byte_i == tpp_pkg::ByteRate) begin
            bytes_left_d = tpp_pkg::RateLen;
            phase_d      = tpp_pkg::PH_SKIP;
          end else if (in_sync_q && trace_byte_i == tpp_pkg::ByteHend) begin
            in_sync_d = 1'b0;
          end else if (in_sync_q && trace_byte_i == tpp_pkg::ByteVmcs) begin
            bytes_left_d = tpp_pkg::VmcsLen;
            phase_d      = tpp_pkg::PH_SKIP;
          end else if (!in_sync_q && trace_byte_i == tpp_pkg::ByteSyncHi) begin
            bytes_left_d = tpp_pkg::SyncLen;
            phase_d      = tpp_pkg::PH_SYNC;
          end else begin
            bytes_left_d = 4'd0;
            in_sync_d    = 1'b0;
          end
        end
        tpp_pkg::PH_SYNC: begin
          if (trace_byte_i != sync_want || bytes_left_q == 4'd0) begin
            phase_d      = tpp_pkg::PH_TOP;
            bytes_left_d = 4'd0;
            in_sync_d    = 1'b0;
          end else begin
            bytes_left_d = bytes_left_q - 4'd1;
            if (bytes_left_q == 4'd1) begin
              phase_d   = tpp_pkg::PH_TOP;
              in_sync_d = 1'b1;
            end
          end
        end
        tpp_pkg::PH_SKIP: begin
          if (bytes_left_q != 4'd0) begin
            bytes_left_d = bytes_left_q - 4'd1;
          end
          if (last_byte) begin
            phase_d = tpp_pkg::PH_TOP;
          end
        end
        tpp_pkg::PH_ADDR: begin
          accum_d = accum_new;
          if (bytes_left_q != 4'd0) begin
            bytes_left_d = bytes_left_q - 4'd1;
          end
          if (last_byte) begin
            phase_d     = tpp_pkg::PH_TOP;
            last_addr_d = addr_rebuilt;
          end
        end
        default: begin
          phase_d = tpp_pkg::PH_TOP;
          if (trace_byte_i == tpp_pkg::BytePad) begin
            phase_d = tpp_pkg::PH_TOP;
          end else if (trace_byte_i == tpp_pkg::ByteExt) begin
            phase_d = tpp_pkg::PH_EXT;
          end else if (trace_byte_i == tpp_pkg::ByteMode) begin
            bytes_left_d = tpp_pkg::ModeLen;
            phase_d      = tpp_pkg::PH_SKIP;
          end else if (hdr_addr && !hdr_bad) begin
            packet_type_d = hdr_event;
            code_d        = hdr_code;
            accum_d       = 64'h0;
            if (hdr_len != 4'd0) begin
              bytes_left_d = hdr_len;
              phase_d      = tpp_pkg::PH_ADDR;
            end
          end else if (!hdr_addr && !in_sync_q &&
                       (!trace_byte_i[0] || trace_byte_i == tpp_pkg::ByteStop)) begin
            phase_d = tpp_pkg::PH_TOP;
          end else begin
            bytes_left_d = 4'd0;
            in_sync_d    = 1'b0;
          end
        end
      endcase
    end
  end

  // event produced by the current byte
  always_comb begin
    res_valid = 1'b0;
    res_event = tpp_pkg::EV_ERR;
    res_bits  = 6'd0;
    res_count = 3'd0;
    res_addr  = 64'h0;
    unique case (phase_q)
      tpp_pkg::PH_EXT: begin
        if (trace_byte_i == tpp_pkg::ByteRate) begin
          res_valid = 1'b0;
        end else if (in_sync_q && trace_byte_i == tpp_pkg::ByteHend) begin
          res_valid = 1'b1;
          res_event = tpp_pkg::EV_HEND;
        end else if (in_sync_q && trace_byte_i == tpp_pkg::ByteVmcs) begin
          res_valid = 1'b0;
        end else if (!in_sync_q && trace_byte_i == tpp_pkg::ByteSyncHi) begin
          res_valid = 1'b0;
        end else begin
          res_valid = 1'b1;
        end
      end
      tpp_pkg::PH_SYNC: begin
        res_valid = (trace_byte_i != sync_want) || (bytes_left_q == 4'd0);
      end
      tpp_pkg::PH_SKIP: begin
        res_valid = 1'b0;
      end
      tpp_pkg::PH_ADDR: begin
        if (last_byte) begin
          res_valid = 1'b1;
          res_event = packet_type_q;
          res_addr  = addr_rebuilt;
        end
      end
      default: begin
        if (trace_byte_i == tpp_pkg::BytePad || trace_byte_i == tpp_pkg::ByteExt ||
            trace_byte_i == tpp_pkg::ByteMode) begin
          res_valid = 1'b0;
        end else if (hdr_addr && !hdr_bad) begin
          if (hdr_len == 4'd0) begin
            res_valid = 1'b1;
            res_event = hdr_event;
            res_addr  = last_addr_q;
          end
        end else if (!hdr_addr && !in_sync_q && !trace_byte_i[0]) begin
          res_valid = 1'b1;
          res_event = tpp_pkg::EV_TNT;
          res_bits  = tnt_bits;
          res_count = tnt_count;
        end else if (!hdr_addr && !in_sync_q && trace_byte_i == tpp_pkg::ByteStop) begin
          res_valid = 1'b1;
          res_event = tpp_pkg::EV_STOP;
        end else begin
          res_valid = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tpp_pkg::PH_TOP;
      bytes_left_q  <= 4'd0;
      packet_type_q <= tpp_pkg::EV_TNT;
      code_q        <= tpp_pkg::CmpNone;
      accum_q       <= 64'h0;
      last_addr_q   <= 64'h0;
      in_sync_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      packet_type_q <= packet_type_d;
      code_q        <= code_d;
      accum_q       <= accum_d;
      last_addr_q   <= last_addr_d;
      in_sync_q     <= in_sync_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_event_q <= res_event;
      out_bits_q  <= res_bits;
      out_count_q <= res_count;
      out_addr_q  <= res_addr;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign event_res_o      = out_event_q;
  assign branch_bits_o    = out_bits_q;
  assign branch_count_o   = out_count_q;
  assign target_address_o = out_addr_q;

  `TPP_ASSERT(a_sync_run_state,
    phase_q == tpp_pkg::PH_SYNC |-> bytes_left_q != 4'd0 && !in_sync_q,
    "sync run state broken")
  `TPP_ASSERT(a_addr_state,
    phase_q == tpp_pkg::PH_ADDR |-> bytes_left_q != 4'd0 &&
      code_q != tpp_pkg::CmpNone && code_q != tpp_pkg::CmpRsvdA &&
      code_q != tpp_pkg::CmpRsvdB,
    "address packet state broken")
  `TPP_ASSERT(a_tnt_count,
    result_valid_o && event_res_o == tpp_pkg::EV_TNT |-> branch_count_o >= 3'd1 &&
      branch_count_o <= 3'd6 && target_address_o == 64'h0,
    "tnt event malformed")
  `TPP_ASSERT_ALWAYS(a_no_bits,
    result_valid_o && event_res_o != tpp_pkg::EV_TNT |-> branch_bits_o == 6'd0 &&
      branch_count_o == 3'd0,
    "branch bits on a non-tnt event")

endmodule

/* dv/trace_packet_parser_tb.sv */
// self-checking testbench for the trace packet parser: byte stream in, event words checked
module trace_packet_parser_tb;

  localparam int unsigned SignBits = tpp_pkg::SignBitsDefault;
  localparam logic [7:0] LongTnt = 8'hA3;
  localparam int unsigned TraceBytes = 1700;

  typedef struct packed {
    tpp_pkg::event_e kind;
    logic [5:0]      bits;
    logic [2:0]      cnt;
    logic [63:0]     addr;
  } trace_event_t;

  typedef enum logic [1:0] {RxOpen, RxRandom, RxSquare, RxSparse} rx_mode_e;

  // directed opening: edge tnt bytes, stop, short tip packets, reserved codes, long tnt,
  // header end outside a sync header, mode, a short pgd packet, an unknown byte, stray vmcs
  localparam logic [7:0] Opening [21] = '{
    tpp_pkg::BytePad, 8'h04, 8'hFE, 8'h80, tpp_pkg::ByteStop,
    {tpp_pkg::CmpNone, tpp_pkg::HdrTip}, {tpp_pkg::Cmp16, tpp_pkg::HdrTip},
    8'hFF, 8'hFF, {tpp_pkg::CmpRsvdB, tpp_pkg::HdrPge},
    {tpp_pkg::CmpRsvdA, tpp_pkg::HdrPgd}, tpp_pkg::ByteExt, LongTnt,
    tpp_pkg::ByteExt, tpp_pkg::ByteHend, tpp_pkg::ByteMode, 8'h5A,
    {tpp_pkg::CmpNone, tpp_pkg::HdrPgd}, 8'h03, tpp_pkg::ByteExt, tpp_pkg::ByteVmcs
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        trace_byte_valid_i = 1'b0;
  logic        trace_byte_ready_o;
  logic [7:0]  trace_byte_i = 8'h00;
  logic        result_valid_o;
  logic        result_ready_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [5:0]  branch_bits_o;
  logic [2:0]  branch_count_o;
  logic [63:0] target_address_o;

  trace_packet_parser uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .trace_byte_valid_i(trace_byte_valid_i),
    .trace_byte_ready_o(trace_byte_ready_o),
    .trace_byte_i     (trace_byte_i),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .event_res_o      (event_res_o),
    .branch_bits_o    (branch_bits_o),
    .branch_count_o   (branch_count_o),
    .target_address_o (target_address_o)
  );

  always #10 clk_i = ~clk_i;

  logic [7:0]   pending_bytes[$];
  trace_event_t expected_events[$];
  int unsigned  stim_bytes = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  event_tally [8];
  int           gap_left = 0;
  int           burst_left = 1;
  int           stall_tick = 0;
  rx_mode_e     rx_mode = RxOpen;

  // decoder state mirrored from the block
  tpp_pkg::phase_e dec_phase = tpp_pkg::PH_TOP;
  logic [3:0]      dec_left = '0;
  tpp_pkg::event_e dec_kind = tpp_pkg::EV_TNT;
  logic [2:0]      dec_code = '0;
  logic [63:0]     dec_accum = '0;
  logic [63:0]     last_addr = '0;
  logic            in_sync_hdr = 1'b0;

  function automatic int addr_payload_bytes(input logic [2:0] code);
    case (code)
      tpp_pkg::Cmp16:   return 2;
      tpp_pkg::Cmp32:   return 4;
      tpp_pkg::CmpSext: return 6;
      tpp_pkg::Cmp48:   return 6;
      tpp_pkg::CmpFull: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] merge_address(input logic [2:0] code, input logic [63:0] p);
    logic [63:0] v;
    case (code)
      tpp_pkg::Cmp16:   return {last_addr[63:16], p[15:0]};
      tpp_pkg::Cmp32:   return {last_addr[63:32], p[31:0]};
      tpp_pkg::CmpSext: begin
        v = p & tpp_pkg::Low48Mask;
        if (v[SignBits-1]) v = v | (~64'h0 << SignBits);
        else v = v & ~(~64'h0 << SignBits);
        return v;
      end
      tpp_pkg::Cmp48:
        return (last_addr & ~tpp_pkg::Low48Mask) | (p & tpp_pkg::Low48Mask);
      tpp_pkg::CmpFull: return p;
      default: return last_addr;
    endcase
  endfunction

  function automatic bit raise_error(output trace_event_t ev);
    ev = '0;
    ev.kind = tpp_pkg::EV_ERR;
    dec_phase = tpp_pkg::PH_TOP;
    dec_left = '0;
    in_sync_hdr = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit open_addr_packet(input logic [7:0] b, input tpp_pkg::event_e kind,
                                          output trace_event_t ev);
    ev = '0;
    if (b[7:5] == tpp_pkg::CmpRsvdA || b[7:5] == tpp_pkg::CmpRsvdB) return raise_error(ev);
    dec_kind = kind;
    dec_code = b[7:5];
    dec_accum = '0;
    // no payload: the header alone repeats the last address
    if (addr_payload_bytes(b[7:5]) == 0) begin
      ev.kind = kind;
      ev.addr = last_addr;
      return 1'b1;
    end
    dec_left = 4'(addr_payload_bytes(b[7:5]));
    dec_phase = tpp_pkg::PH_ADDR;
    return 1'b0;
  endfunction

  // advances the mirrored decoder by one byte; returns 1 when an event is due
  function automatic bit decode_byte(input logic [7:0] b, output trace_event_t ev);
    bit          at_top;
    bit          got;
    int          n;
    int          k;
    logic [7:0]  want;
    logic [63:0] payload;
    ev = '0;
    at_top = 1'b0;
    got = 1'b0;
    case (dec_phase)
      tpp_pkg::PH_EXT: begin
        dec_phase = tpp_pkg::PH_TOP;
        if (b == tpp_pkg::ByteRate) begin
          dec_left = tpp_pkg::RateLen;
          dec_phase = tpp_pkg::PH_SKIP;
        end else if (in_sync_hdr && b == tpp_pkg::ByteHend) begin
          in_sync_hdr = 1'b0;
          ev.kind = tpp_pkg::EV_HEND;
          got = 1'b1;
        end else if (in_sync_hdr && b == tpp_pkg::ByteVmcs) begin
          dec_left = tpp_pkg::VmcsLen;
          dec_phase = tpp_pkg::PH_SKIP;
        end else if (!in_sync_hdr && b == tpp_pkg::ByteSyncHi) begin
          dec_left = tpp_pkg::SyncLen;
          dec_phase = tpp_pkg::PH_SYNC;
        end else begin
          got = raise_error(ev);
        end
      end
      tpp_pkg::PH_SYNC: begin
        want = dec_left[0] ? tpp_pkg::ByteSyncHi : tpp_pkg::ByteExt;
        if (b != want || dec_left == 0) begin
          got = raise_error(ev);
        end else begin
          dec_left--;
          if (dec_left == 0) begin
            dec_phase = tpp_pkg::PH_TOP;
            in_sync_hdr = 1'b1;
          end
        end
      end
      tpp_pkg::PH_SKIP: begin
        if (dec_left > 0) dec_left--;
        if (dec_left == 0) dec_phase = tpp_pkg::PH_TOP;
      end
      tpp_pkg::PH_ADDR: begin
        // payload is little endian, shift in from the top
        dec_accum = {b, dec_accum[63:8]};
        if (dec_left > 0) dec_left--;
        if (dec_left == 0) begin
          dec_phase = tpp_pkg::PH_TOP;
          n = addr_payload_bytes(dec_code);
          if (n < 2 || n > 8) n = 8;
          payload = dec_accum >> (64 - 8 * n);
          last_addr = merge_address(dec_code, payload);
          ev.kind = dec_kind;
          ev.addr = last_addr;
          got = 1'b1;
        end
      end
      default: at_top = 1'b1;
    endcase
    if (at_top) begin
      dec_phase = tpp_pkg::PH_TOP;
      if (b == tpp_pkg::BytePad) begin
        got = 1'b0;
      end else if (b == tpp_pkg::ByteExt) begin
        dec_phase = tpp_pkg::PH_EXT;
      end else if (b == tpp_pkg::ByteMode) begin
        dec_left = tpp_pkg::ModeLen;
        dec_phase = tpp_pkg::PH_SKIP;
      end else if (b[4:0] == tpp_pkg::HdrFup) begin
        got = open_addr_packet(b, tpp_pkg::EV_FUP, ev);
      end else if (in_sync_hdr) begin
        got = raise_error(ev);
      end else if (b[0] == 1'b0) begin
        k = 7;
        while (k > 1 && b[k] == 1'b0) k--;
        ev.kind = tpp_pkg::EV_TNT;
        ev.cnt = 3'(k - 1);
        ev.bits = 6'((int'(b) >> 1) & ((1 << (k - 1)) - 1));
        got = 1'b1;
      end else if (b[4:0] == tpp_pkg::HdrPge) begin
        got = open_addr_packet(b, tpp_pkg::EV_PGE, ev);
      end else if (b[4:0] == tpp_pkg::HdrPgd) begin
        got = open_addr_packet(b, tpp_pkg::EV_PGD, ev);
      end else if (b[4:0] == tpp_pkg::HdrTip) begin
        got = open_addr_packet(b, tpp_pkg::EV_TIP, ev);
      end else if (b == tpp_pkg::ByteStop) begin
        ev.kind = tpp_pkg::EV_STOP;
        got = 1'b1;
      end else begin
        got = raise_error(ev);
      end
    end
    return got;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    if (b != tpp_pkg::BytePad) stim_bytes++;
  endtask

  function automatic logic [2:0] pick_code();
    if ($urandom_range(0, 11) == 0)
      return $urandom_range(0, 1) ? tpp_pkg::CmpRsvdA : tpp_pkg::CmpRsvdB;
    case ($urandom_range(0, 5))
      0: return tpp_pkg::CmpNone;
      1: return tpp_pkg::Cmp16;
      2: return tpp_pkg::Cmp32;
      3: return tpp_pkg::CmpSext;
      4: return tpp_pkg::Cmp48;
      default: return tpp_pkg::CmpFull;
    endcase
  endfunction

  task automatic push_addr_packet(input logic [4:0] hdr, input logic [2:0] code);
    push_byte({code, hdr});
    repeat (addr_payload_bytes(code)) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_skip_packet(input logic [7:0] sub, input int len);
    push_byte(tpp_pkg::ByteExt);
    push_byte(sub);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_sync_run();
    repeat (8) begin
      push_byte(tpp_pkg::ByteExt);
      push_byte(tpp_pkg::ByteSyncHi);
    end
  endtask

  task automatic push_sync_header();
    push_sync_run();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0:       push_byte(tpp_pkg::BytePad);
        1, 2, 3: push_addr_packet(tpp_pkg::HdrFup, pick_code());
        4: begin
          push_byte(tpp_pkg::ByteMode);
          push_byte(8'($urandom_range(0, 255)));
        end
        5:       push_skip_packet(tpp_pkg::ByteRate, tpp_pkg::RateLen);
        6, 7:    push_skip_packet(tpp_pkg::ByteVmcs, tpp_pkg::VmcsLen);
        8:       push_byte(8'($urandom_range(0, 255)));
        default: begin
          push_byte(tpp_pkg::ByteExt);
          push_byte(tpp_pkg::ByteSyncHi);
        end
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      push_byte(tpp_pkg::ByteExt);
      push_byte(tpp_pkg::ByteHend);
    end
  endtask

  task automatic flag_mismatch(input string why, input trace_event_t want,
                               input trace_event_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected kind %0d bits %h count %0d addr %h,",
                " got kind %0d bits %h count %0d addr %h"},
               why, want.kind, want.bits, want.cnt, want.addr,
               got.kind, got.bits, got.cnt, got.addr);
  endtask

  // sender: bursts of words with random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      trace_byte_valid_i <= 1'b0;
    end else if (!trace_byte_valid_i || trace_byte_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        trace_byte_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        trace_byte_valid_i <= 1'b1;
        trace_byte_i <= pending_bytes.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        trace_byte_valid_i <= 1'b0;
      end
    end
  end

  // receiver: the stall pattern is picked anew at random intervals
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (stall_tick == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        stall_tick = $urandom_range(16, 96);
      end else begin
        stall_tick--;
      end
      case (rx_mode)
        RxOpen:   result_ready_i <= 1'b1;
        RxRandom: result_ready_i <= ($urandom_range(0, 3) != 0);
        RxSquare: result_ready_i <= stall_tick[2];
        default:  result_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // monitor: check the outgoing word first, then predict from the incoming one
  always @(posedge clk_i) begin
    trace_event_t got_ev;
    trace_event_t want_ev;
    if (rst_ni) begin
      if (result_valid_o && result_ready_i) begin
        got_ev.kind = tpp_pkg::event_e'(event_res_o);
        got_ev.bits = branch_bits_o;
        got_ev.cnt = branch_count_o;
        got_ev.addr = target_address_o;
        event_tally[event_res_o]++;
        if (expected_events.size() == 0) begin
          flag_mismatch("unexpected event", '0, got_ev);
        end else begin
          want_ev = expected_events.pop_front();
          if (got_ev.kind !== want_ev.kind || got_ev.bits !== want_ev.bits ||
              got_ev.cnt !== want_ev.cnt || got_ev.addr !== want_ev.addr)
            flag_mismatch("wrong field", want_ev, got_ev);
        end
      end
      if (trace_byte_valid_i && trace_byte_ready_o) begin
        bytes_taken++;
        if (decode_byte(trace_byte_i, want_ev)) expected_events.push_back(want_ev);
      end
    end
  end

  initial begin
    logic [7:0] b;
    int         k;
    foreach (Opening[i]) push_byte(Opening[i]);
    while (stim_bytes < TraceBytes) begin
      case ($urandom_range(0, 19))
        0, 1: push_byte(tpp_pkg::BytePad);
        2, 3, 4: push_byte({6'($urandom_range(1, 63)), 1'($urandom_range(0, 1)), 1'b0});
        5, 6, 7, 8, 9, 10: begin
          case ($urandom_range(0, 3))
            0: push_addr_packet(tpp_pkg::HdrTip, pick_code());
            1: push_addr_packet(tpp_pkg::HdrPge, pick_code());
            2: push_addr_packet(tpp_pkg::HdrPgd, pick_code());
            default: push_addr_packet(tpp_pkg::HdrFup, pick_code());
          endcase
        end
        11: begin
          push_byte(tpp_pkg::ByteMode);
          push_byte(8'($urandom_range(0, 255)));
        end
        12: push_skip_packet(tpp_pkg::ByteRate, tpp_pkg::RateLen);
        13: push_byte(tpp_pkg::ByteStop);
        14, 15: push_sync_header();
        16: begin
          // sync run cut short by the wrong byte
          push_byte(tpp_pkg::ByteExt);
          push_byte(tpp_pkg::ByteSyncHi);
          k = $urandom_range(0, 13);
          for (int i = 0; i < k; i++)
            push_byte(i[0] ? tpp_pkg::ByteSyncHi : tpp_pkg::ByteExt);
          push_byte(k[0] ? tpp_pkg::ByteExt : tpp_pkg::ByteSyncHi);
        end
        17: begin
          push_byte(tpp_pkg::ByteExt);
          case ($urandom_range(0, 3))
            0: push_byte(tpp_pkg::ByteHend);
            1: push_byte(tpp_pkg::ByteVmcs);
            2: push_byte(LongTnt);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
        default: begin
          b = 8'($urandom_range(0, 255));
          push_byte(b);
        end
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || trace_byte_valid_i) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d trace bytes; events tnt %0d tip %0d pge %0d pgd %0d fup %0d",
             bytes_taken, event_tally[tpp_pkg::EV_TNT], event_tally[tpp_pkg::EV_TIP],
             event_tally[tpp_pkg::EV_PGE], event_tally[tpp_pkg::EV_PGD],
             event_tally[tpp_pkg::EV_FUP]);
    $display("header end %0d, stop %0d, error %0d, mismatched words %0d",
             event_tally[tpp_pkg::EV_HEND], event_tally[tpp_pkg::EV_STOP],
             event_tally[tpp_pkg::EV_ERR], mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* trace_packet_parser.f */
+incdir+hw/rtl
hw/rtl/tpp_pkg.sv
hw/rtl/trace_packet_parser.sv
dv/trace_packet_parser_tb.sv
